@@ rtl/snapcat_pkg.sv @@
package snapcat_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_ACT,
        S_OUT
    } t_state;

    localparam logic [3:0] OP_CREATE     = 4'd0;
    localparam logic [3:0] OP_DELETE     = 4'd1;
    localparam logic [3:0] OP_HOLD       = 4'd2;
    localparam logic [3:0] OP_RELEASE    = 4'd3;
    localparam logic [3:0] OP_LOOKUP     = 4'd4;
    localparam logic [3:0] OP_COUNT_ALL  = 4'd5;
    localparam logic [3:0] OP_COUNT_DS   = 4'd6;
    localparam logic [3:0] OP_NEWEST     = 4'd7;
    localparam logic [3:0] OP_ADVANCE    = 4'd8;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_EXISTS   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_BUSY     = 3'd5;
    localparam logic [2:0] ST_OVERFLOW = 3'd6;

    typedef struct packed {
        logic [31:0] holds;
        logic [63:0] previous;
        logic [63:0] birth_txg;
        logic [63:0] root;
        logic [3:0]  name_length;
        logic [63:0] name;
        logic [63:0] dataset;
    } t_entry;

    function automatic logic [63:0] name_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < len) m[8*b +: 8] = 8'hFF;
        end
        return m;
    endfunction

endpackage

@@ rtl/snapcat_ram.sv @@
module snapcat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/snapshot_catalog_table_unit.sv @@
// Channel   | Direction | Beat contents
// s_axis    | in        | tdata: op, dataset_key, name_bytes, name_length, root_address,
//           |           |        target_id, new_txg (lowest bits first)
// m_axis    | out       | tdata: one result per input beat
// cfg       | in        | i_cfg_data: start_txg, loads the txg counter
//
// Create, count and newest scan all used slots through the single entry RAM read port,
// one slot a cycle. Delete, hold, release and lookup read the one slot the id maps to.
// Advance, malformed creates and unknown ops go straight to the result beat. After the
// result beat is taken the block returns to idle before it takes the next beat. The
// result beat holds until taken. Reset is synchronous; it clears the present bits, the
// slot count and the txg counter.
module snapshot_catalog_table_unit
    import snapcat_pkg::*;
#(
    parameter int SLOTS          = 64,
    parameter int NAME_MAX_BYTES = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op[3:0], dataset_key[67:4], name_bytes[131:68], name_length[135:132],
    // root_address[199:136], target_id[263:200], new_txg[327:264]
    input  logic [327:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], result_id[66:3], entry_dataset[130:67], entry_name[194:131],
    // entry_name_length[198:195], entry_root[262:199], entry_birth_txg[326:263],
    // entry_previous[390:327], entry_holds[422:391], present_count[429:423],
    // txg_now[493:430], zero[495:494]
    output logic [495:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [63:0]  i_cfg_data
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int EW = $bits(t_entry);

    logic [3:0]  in_op;
    logic [63:0] in_ds, in_name, in_root, in_target, in_newtxg;
    logic [3:0]  in_len;

    assign in_op     = s_axis_tdata[3:0];
    assign in_ds     = s_axis_tdata[67:4];
    assign in_name   = s_axis_tdata[131:68];
    assign in_len    = s_axis_tdata[135:132];
    assign in_root   = s_axis_tdata[199:136];
    assign in_target = s_axis_tdata[263:200];
    assign in_newtxg = s_axis_tdata[327:264];

    t_state            r_state, n_state;
    logic [CW-1:0]     r_used, n_used;
    logic [SLOTS-1:0]  r_present, n_present;
    logic [63:0]       r_txg, n_txg;
    logic [CW-1:0]     r_addr, n_addr;
    logic              r_rv, n_rv;
    logic [IW-1:0]     r_ridx, n_ridx;
    logic              r_hit, n_hit;
    logic [CW-1:0]     r_best, n_best;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [IW-1:0]     r_tidx, n_tidx;
    logic [3:0]        r_op, n_op;
    logic [63:0]       r_ds, n_ds, r_name, n_name, r_root, n_root, r_target, n_target;
    logic [3:0]        r_len, n_len;
    logic [2:0]        r_status, n_status;
    logic [63:0]       r_rid, n_rid;
    t_entry            r_ent, n_ent;
    logic [6:0]        r_pcnt, n_pcnt;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr, ram_raddr;
    t_entry            ram_wdata, rd;
    logic [EW-1:0]     ram_rdata;
    logic              seen, ds_match, tfound;

    snapcat_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd = t_entry'(ram_rdata);

    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {2'b00, r_txg, r_pcnt, r_ent.holds, r_ent.previous,
                            r_ent.birth_txg, r_ent.root, r_ent.name_length,
                            r_ent.name, r_ent.dataset, r_rid, r_status};

    // Ids are handed out in slot order starting at one, so id k lives in slot k-1.
    assign tfound = (r_target != 64'd0) && (r_target <= 64'(r_used)) && r_present[r_tidx];

    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_present = r_present;
        n_txg     = r_txg;
        n_addr    = r_addr;
        n_rv      = 1'b0;
        n_ridx    = r_ridx;
        n_hit     = r_hit;
        n_best    = r_best;
        n_cnt     = r_cnt;
        n_tidx    = r_tidx;
        n_op      = r_op;
        n_ds      = r_ds;
        n_name    = r_name;
        n_root    = r_root;
        n_target  = r_target;
        n_len     = r_len;
        n_status  = r_status;
        n_rid     = r_rid;
        n_ent     = r_ent;
        n_pcnt    = r_pcnt;
        ram_we    = 1'b0;
        ram_waddr = r_tidx;
        ram_wdata = rd;
        ram_raddr = r_addr[IW-1:0];
        seen      = r_rv && r_present[r_ridx];
        ds_match  = rd.dataset == r_ds;

        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) n_txg = i_cfg_data;
                if (s_axis_tvalid && s_axis_tready) begin
                    n_op     = in_op;
                    n_ds     = in_ds;
                    n_name   = in_name & name_mask(in_len);
                    n_len    = in_len;
                    n_root   = in_root;
                    n_target = in_target;
                    n_tidx   = IW'(in_target - 64'd1);
                    n_addr   = '0;
                    n_hit    = 1'b0;
                    n_best   = '0;
                    n_cnt    = '0;
                    n_status = ST_OK;
                    n_rid    = '0;
                    n_ent    = '0;
                    n_pcnt   = '0;
                    priority case (in_op)
                        OP_CREATE: begin
                            if (in_ds == 64'd0 || in_len == 4'd0 ||
                                in_len > 4'(NAME_MAX_BYTES)) begin
                                n_status = ST_INVALID;
                                n_state  = S_OUT;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_COUNT_ALL, OP_COUNT_DS, OP_NEWEST: n_state = S_SCAN;
                        OP_DELETE, OP_HOLD, OP_RELEASE, OP_LOOKUP: n_state = S_READ;
                        OP_ADVANCE: begin
                            if (in_newtxg < r_txg) n_status = ST_INVALID;
                            else n_txg = in_newtxg;
                            n_state = S_OUT;
                        end
                        default: begin
                            n_status = ST_INVALID;
                            n_state  = S_OUT;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_addr < r_used) begin
                    n_addr = r_addr + CW'(1);
                    n_rv   = 1'b1;
                    n_ridx = r_addr[IW-1:0];
                end
                // Later slots hold larger ids, so the last match is the newest.
                if (seen && ds_match) begin
                    n_best = CW'(r_ridx) + CW'(1);
                    if (rd.name_length == r_len && rd.name == r_name) n_hit = 1'b1;
                end
                if (seen && (r_op == OP_COUNT_ALL || ds_match)) n_cnt = r_cnt + CW'(1);
                if (r_addr == r_used && !r_rv) begin
                    n_state = S_OUT;
                    priority case (r_op)
                        OP_CREATE: begin
                            if (r_hit) begin
                                n_status = ST_EXISTS;
                            end else if (r_used == CW'(SLOTS)) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_used[IW-1:0];
                                ram_wdata = '{holds: 32'd0, previous: 64'(r_best),
                                              birth_txg: r_txg + 64'd1, root: r_root,
                                              name_length: r_len, name: r_name,
                                              dataset: r_ds};
                                n_txg     = r_txg + 64'd1;
                                n_used    = r_used + CW'(1);
                                n_present[r_used[IW-1:0]] = 1'b1;
                                n_rid     = 64'(r_used) + 64'd1;
                            end
                        end
                        OP_NEWEST: n_rid  = 64'(r_best);
                        default:   n_pcnt = 7'(r_cnt);
                    endcase
                end
            end
            S_READ: begin
                ram_raddr = r_tidx;
                n_state   = S_ACT;
            end
            S_ACT: begin
                n_state = S_OUT;
                if (!tfound) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    priority case (r_op)
                        OP_DELETE: begin
                            if (rd.holds != 32'd0) n_status = ST_BUSY;
                            else n_present[r_tidx] = 1'b0;
                        end
                        OP_HOLD: begin
                            if (rd.holds == 32'hFFFF_FFFF) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                ram_we          = 1'b1;
                                ram_wdata.holds = rd.holds + 32'd1;
                            end
                        end
                        OP_RELEASE: begin
                            if (rd.holds == 32'd0) begin
                                n_status = ST_INVALID;
                            end else begin
                                ram_we          = 1'b1;
                                ram_wdata.holds = rd.holds - 32'd1;
                            end
                        end
                        default: n_ent = rd;
                    endcase
                end
            end
            S_OUT: begin
                if (m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_present <= '0;
            r_txg     <= '0;
            r_rv      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_present <= n_present;
            r_txg     <= n_txg;
            r_rv      <= n_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_ridx   <= n_ridx;
        r_hit    <= n_hit;
        r_best   <= n_best;
        r_cnt    <= n_cnt;
        r_tidx   <= n_tidx;
        r_op     <= n_op;
        r_ds     <= n_ds;
        r_name   <= n_name;
        r_root   <= n_root;
        r_target <= n_target;
        r_len    <= n_len;
        r_status <= n_status;
        r_rid    <= n_rid;
        r_ent    <= n_ent;
        r_pcnt   <= n_pcnt;
    end
endmodule

@@ rtl/snapcat_chk.sv @@
module snapcat_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [495:0] m_axis_tdata
);
    // A result beat waiting on the sink keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Only one operation is in flight: no new beat while one is being worked on.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while a result is pending");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] != 3'd7)
        else $error("undefined status code");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");
endmodule

bind snapshot_catalog_table_unit snapcat_chk u_snapcat_chk (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import snapcat_pkg::*;

    localparam int  TABLE_SLOTS  = 64;
    localparam int  DRAIN_CYCLES = 80;
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  PHASE_ITEMS  = 345;

    // Input beat, first field in the lowest bits.
    typedef struct packed {
        logic [63:0] new_txg;
        logic [63:0] target_id;
        logic [63:0] root_address;
        logic [3:0]  name_length;
        logic [63:0] name_bytes;
        logic [63:0] dataset_key;
        logic [3:0]  op;
    } t_request;

    // Result beat, first field in the lowest bits.
    typedef struct packed {
        logic [1:0]  pad;
        logic [63:0] txg_now;
        logic [6:0]  present_count;
        logic [31:0] entry_holds;
        logic [63:0] entry_previous;
        logic [63:0] entry_birth_txg;
        logic [63:0] entry_root;
        logic [3:0]  entry_name_length;
        logic [63:0] entry_name;
        logic [63:0] entry_dataset;
        logic [63:0] result_id;
        logic [2:0]  status;
    } t_reply;

    typedef struct {
        t_request   req;
        bit         typed;
        logic [2:0] status;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // op, dataset_key, name_bytes, name_length, root_address, target_id, new_txg
    logic [327:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // status, result_id, entry_dataset, entry_name, entry_name_length, entry_root,
    // entry_birth_txg, entry_previous, entry_holds, present_count, txg_now, zero
    logic [495:0] m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [63:0]  i_cfg_data = '0;

    snapshot_catalog_table_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Catalog mirror.
    bit          cat_present [TABLE_SLOTS];
    logic [63:0] cat_id      [TABLE_SLOTS];
    logic [63:0] cat_dataset [TABLE_SLOTS];
    logic [63:0] cat_name    [TABLE_SLOTS];
    logic [3:0]  cat_len     [TABLE_SLOTS];
    logic [63:0] cat_root    [TABLE_SLOTS];
    logic [63:0] cat_ctxg    [TABLE_SLOTS];
    logic [63:0] cat_prev    [TABLE_SLOTS];
    logic [31:0] cat_holds   [TABLE_SLOTS];
    int          cat_used = 0;
    logic [63:0] cat_next_id = 64'd1;
    logic [63:0] cat_txg = '0;

    t_reply pending_replies[$];
    t_row   directed_rows[$];
    int     error_count = 0;
    int     cycle_count = 0;
    int     burst_left = 0;

    task automatic report(input string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic int slot_of(input logic [63:0] id);
        for (int i = 0; i < cat_used; i++)
            if (cat_present[i] && cat_id[i] == id) return i;
        return -1;
    endfunction

    function automatic logic [63:0] newest_id(input logic [63:0] ds);
        logic [63:0] best;
        best = '0;
        for (int i = 0; i < cat_used; i++)
            if (cat_present[i] && cat_dataset[i] == ds && cat_id[i] > best) best = cat_id[i];
        return best;
    endfunction

    function automatic t_reply catalog_step(input t_request r);
        t_reply      y;
        logic [63:0] nm;
        int          s;
        int          n;
        bit          taken;
        y = '0;
        y.status = ST_OK;
        case (r.op)
            OP_CREATE: begin
                nm = '0;
                for (int b = 0; b < 8; b++)
                    if (b < r.name_length) nm[8*b +: 8] = r.name_bytes[8*b +: 8];
                taken = 1'b0;
                for (int i = 0; i < cat_used; i++)
                    if (cat_present[i] && cat_dataset[i] == r.dataset_key &&
                        cat_len[i] == r.name_length && cat_name[i] == nm) taken = 1'b1;
                if (r.dataset_key == 0 || r.name_length == 0 || r.name_length > 8) begin
                    y.status = ST_INVALID;
                end else if (taken) begin
                    y.status = ST_EXISTS;
                end else if (cat_used >= TABLE_SLOTS) begin
                    y.status = ST_FULL;
                end else begin
                    s = cat_used;
                    cat_prev[s]    = newest_id(r.dataset_key);
                    cat_txg        = cat_txg + 64'd1;
                    cat_id[s]      = cat_next_id;
                    cat_next_id    = cat_next_id + 64'd1;
                    cat_dataset[s] = r.dataset_key;
                    cat_name[s]    = nm;
                    cat_len[s]     = r.name_length;
                    cat_root[s]    = r.root_address;
                    cat_ctxg[s]    = cat_txg;
                    cat_holds[s]   = '0;
                    cat_present[s] = 1'b1;
                    cat_used++;
                    y.result_id = cat_id[s];
                end
            end
            OP_DELETE, OP_HOLD, OP_RELEASE, OP_LOOKUP: begin
                s = slot_of(r.target_id);
                if (s < 0) begin
                    y.status = ST_NOTFOUND;
                end else if (r.op == OP_DELETE) begin
                    if (cat_holds[s] != 0) y.status = ST_BUSY;
                    else cat_present[s] = 1'b0;
                end else if (r.op == OP_HOLD) begin
                    if (cat_holds[s] == 32'hFFFF_FFFF) y.status = ST_OVERFLOW;
                    else cat_holds[s]++;
                end else if (r.op == OP_RELEASE) begin
                    if (cat_holds[s] == 0) y.status = ST_INVALID;
                    else cat_holds[s]--;
                end else begin
                    y.entry_dataset     = cat_dataset[s];
                    y.entry_name        = cat_name[s];
                    y.entry_name_length = cat_len[s];
                    y.entry_root        = cat_root[s];
                    y.entry_birth_txg   = cat_ctxg[s];
                    y.entry_previous    = cat_prev[s];
                    y.entry_holds       = cat_holds[s];
                end
            end
            OP_COUNT_ALL, OP_COUNT_DS: begin
                n = 0;
                for (int i = 0; i < cat_used; i++)
                    if (cat_present[i] && (r.op == OP_COUNT_ALL ||
                                           cat_dataset[i] == r.dataset_key)) n++;
                y.present_count = 7'(n);
            end
            OP_NEWEST: y.result_id = newest_id(r.dataset_key);
            OP_ADVANCE: begin
                if (r.new_txg < cat_txg) y.status = ST_INVALID;
                else cat_txg = r.new_txg;
            end
            default: y.status = ST_INVALID;
        endcase
        y.txg_now = cat_txg;
        return y;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic t_request random_request();
        t_request r;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)      r.op = OP_CREATE;
        else if (pick < 33) r.op = OP_DELETE;
        else if (pick < 43) r.op = OP_HOLD;
        else if (pick < 53) r.op = OP_RELEASE;
        else if (pick < 68) r.op = OP_LOOKUP;
        else if (pick < 72) r.op = OP_COUNT_ALL;
        else if (pick < 78) r.op = OP_COUNT_DS;
        else if (pick < 86) r.op = OP_NEWEST;
        else if (pick < 94) r.op = OP_ADVANCE;
        else                r.op = 4'($urandom_range(OP_ADVANCE + 1, 15));

        // A few datasets and short names make name clashes and links common.
        pick = $urandom_range(0, 99);
        if (pick < 80)      r.dataset_key = 64'($urandom_range(1, 4));
        else if (pick < 90) r.dataset_key = rand64();
        else if (pick < 95) r.dataset_key = '0;
        else                r.dataset_key = '1;

        r.name_bytes = rand64();
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            r.name_bytes[7:0] = 8'h41 + 8'($urandom_range(0, 2));
            r.name_length     = 4'd1;
        end else if (pick < 90) begin
            r.name_length = 4'($urandom_range(1, 8));
        end else begin
            r.name_length = 4'($urandom_range(0, 15));
        end
        r.root_address = rand64();

        pick = $urandom_range(0, 99);
        if (pick < 85)      r.target_id = 64'($urandom_range(0, 32'(cat_next_id)));
        else if (pick < 93) r.target_id = rand64();
        else                r.target_id = '1;

        pick = $urandom_range(0, 99);
        if (pick < 60)      r.new_txg = cat_txg + 64'($urandom_range(0, 5));
        else if (pick < 80) r.new_txg = cat_txg - 64'($urandom_range(1, 3));
        else                r.new_txg = rand64();
        return r;
    endfunction

    task automatic send_request(input t_request r, input bit typed, input logic [2:0] st);
        t_reply y;
        s_axis_tdata  <= r;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        y = catalog_step(r);
        if (typed) y.status = st;
        pending_replies.push_back(y);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        // Leave the block idle for a while before the next configuration write.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_start_txg(input logic [63:0] value);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cat_txg = value;
    endtask

    task automatic add_row(input logic [3:0] op, input logic [63:0] ds, input logic [63:0] nm,
                           input logic [3:0] len, input logic [63:0] tgt,
                           input logic [63:0] ntxg, input bit typed, input logic [2:0] st);
        t_row w;
        w.req = '{new_txg: ntxg, target_id: tgt, root_address: rand64(), name_length: len,
                  name_bytes: nm, dataset_key: ds, op: op};
        w.typed  = typed;
        w.status = st;
        directed_rows.push_back(w);
    endtask

    task automatic check_reply(input t_reply got);
        t_reply want;
        if (pending_replies.size() == 0) begin
            report("result beat with nothing outstanding");
            return;
        end
        want = pending_replies.pop_front();
        if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.result_id !== want.result_id)
            report($sformatf("result_id %h, expected %h", got.result_id, want.result_id));
        if (got.entry_dataset !== want.entry_dataset)
            report($sformatf("entry_dataset %h, expected %h",
                             got.entry_dataset, want.entry_dataset));
        if (got.entry_name !== want.entry_name)
            report($sformatf("entry_name %h, expected %h", got.entry_name, want.entry_name));
        if (got.entry_name_length !== want.entry_name_length)
            report($sformatf("entry_name_length %0d, expected %0d",
                             got.entry_name_length, want.entry_name_length));
        if (got.entry_root !== want.entry_root)
            report($sformatf("entry_root %h, expected %h", got.entry_root, want.entry_root));
        if (got.entry_birth_txg !== want.entry_birth_txg)
            report($sformatf("entry_birth_txg %h, expected %h",
                             got.entry_birth_txg, want.entry_birth_txg));
        if (got.entry_previous !== want.entry_previous)
            report($sformatf("entry_previous %h, expected %h",
                             got.entry_previous, want.entry_previous));
        if (got.entry_holds !== want.entry_holds)
            report($sformatf("entry_holds %0d, expected %0d", got.entry_holds, want.entry_holds));
        if (got.present_count !== want.present_count)
            report($sformatf("present_count %0d, expected %0d",
                             got.present_count, want.present_count));
        if (got.txg_now !== want.txg_now)
            report($sformatf("txg_now %h, expected %h", got.txg_now, want.txg_now));
        if (got.pad !== want.pad)
            report($sformatf("padding bits %b not zero", got.pad));
    endtask

    // Result side: each beat is checked, and the ready pattern follows the top two bits of stall_phase.
    logic [9:0] stall_phase = '0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) check_reply(t_reply'(m_axis_tdata));
            stall_phase <= stall_phase + 10'd1;
            case (stall_phase[9:8])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
                2'd2: m_axis_tready <= (stall_phase[2:0] == 3'd0);
                default: m_axis_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    initial begin
        // Unchecked rows leave the expectation to the mirror.
        add_row(OP_COUNT_ALL, 0, 0, 0, 0, 0, 1, ST_OK);
        add_row(OP_ADVANCE + 4'd1, 0, 0, 0, 0, 0, 1, ST_INVALID);
        add_row(4'hF, '1, '1, 4'hF, '1, '1, 1, ST_INVALID);
        add_row(OP_CREATE, 0, 64'h41, 1, 0, 0, 1, ST_INVALID);
        add_row(OP_CREATE, 1, 64'h41, 0, 0, 0, 1, ST_INVALID);
        add_row(OP_CREATE, 1, 64'h41, 9, 0, 0, 1, ST_INVALID);
        // Bytes past the name length must be dropped, so the next create clashes.
        add_row(OP_CREATE, 1, 64'hDEAD_BEEF_0000_0041, 1, 0, 0, 1, ST_OK);
        add_row(OP_CREATE, 1, 64'h41, 1, 0, 0, 1, ST_EXISTS);
        add_row(OP_CREATE, '1, '1, 8, 0, 0, 1, ST_OK);
        add_row(OP_CREATE, 1, 64'h4242, 2, 0, 0, 0, ST_OK);
        add_row(OP_LOOKUP, 0, 0, 0, 3, 0, 0, ST_OK);
        add_row(OP_LOOKUP, 0, 0, 0, 2, 0, 0, ST_OK);
        add_row(OP_LOOKUP, 0, 0, 0, 0, 0, 1, ST_NOTFOUND);
        add_row(OP_LOOKUP, 0, 0, 0, '1, 0, 1, ST_NOTFOUND);
        add_row(OP_HOLD, 0, 0, 0, 1, 0, 1, ST_OK);
        add_row(OP_DELETE, 0, 0, 0, 1, 0, 1, ST_BUSY);
        add_row(OP_RELEASE, 0, 0, 0, 1, 0, 1, ST_OK);
        add_row(OP_RELEASE, 0, 0, 0, 1, 0, 1, ST_INVALID);
        add_row(OP_DELETE, 0, 0, 0, 1, 0, 1, ST_OK);
        add_row(OP_HOLD, 0, 0, 0, 1, 0, 1, ST_NOTFOUND);
        add_row(OP_NEWEST, 1, 0, 0, 0, 0, 0, ST_OK);
        add_row(OP_COUNT_DS, 1, 0, 0, 0, 0, 0, ST_OK);
        add_row(OP_ADVANCE, 0, 0, 0, 0, 2, 1, ST_INVALID);
        add_row(OP_ADVANCE, 0, 0, 0, 0, 3, 1, ST_OK);
        add_row(OP_ADVANCE, 0, 0, 0, 0, '1, 1, ST_OK);
        // The txg counter wraps to zero on this create.
        add_row(OP_CREATE, 5, 64'h43, 1, 0, 0, 0, ST_OK);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_start_txg('0);
        foreach (directed_rows[k])
            send_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].status);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_start_txg(rand64());
                1: write_start_txg('1);
                2: write_start_txg(64'($urandom_range(0, 100)));
                default: write_start_txg(64'hFFFF_FFFF_FFFF_FFF0);
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) send_request(random_request(), 0, ST_OK);
            drain();
        end

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ snapshot_catalog_table_unit.f @@
rtl/snapcat_pkg.sv
rtl/snapcat_ram.sv
rtl/snapshot_catalog_table_unit.sv
rtl/snapcat_chk.sv
tb/tb_top.sv
